// ===== rtl/kls_pkg.sv =====
// shared constants, codes and types of the keyed lifo stack
package kls_pkg;

   localparam int DEPTH     = 8;
   localparam int KEY_WIDTH = 64;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int COUNT_W   = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_SEARCH = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   typedef logic [KEY_WIDTH-1:0] key_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/keyed_lifo_stack.sv =====
// top level of the keyed lifo stack: row of cells, fill count and result register
//
//  channel | direction | fields
//  req     | in        | cmd, key
//  rsp     | out       | popped_key, found, status, entry_count, top_key, top_valid
//
// one request is taken per cycle while req_ready is high; its result is registered
// in the output register in the cycle after acceptance. all cells compare in
// parallel and shift down on removal. req_ready is low only while a result
// waits and rsp_ready is low. reset clears the fill count and the result
// valid flag; cell contents are not cleared and are only read below the count.
module keyed_lifo_stack
   import kls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_popped_key,
   output logic        rsp_found,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_entry_count,
   output logic [63:0] rsp_top_key,
   output logic        rsp_top_valid
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        popped_ff, popped_in;
   logic               found_ff, found_in;
   logic [1:0]         status_ff, status_in;
   logic [63:0]        top_ff, top_in;

   key_type            key_w;
   key_type            cell_key [DEPTH];
   key_type            cell_next [DEPTH];
   logic [DEPTH-1:0]   cell_match;
   cell_ctrl_type      cell_ctrl [DEPTH];

   logic               accept;
   logic               any_hit;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   top_idx;
   logic [IDX_W-1:0]   next_top_idx;

   assign key_w     = req_key[KEY_WIDTH-1:0];
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign top_idx   = IDX_W'(count_ff - COUNT_W'(1));

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         kls_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .new_key   (key_w),
            .upper_key (cell_key[(g + 1) % DEPTH]),
            .key_q     (cell_key[g]),
            .key_next  (cell_next[g]),
            .match     (cell_match[g])
         );
      end
   endgenerate

   // topmost occupied match wins
   always_comb begin
      any_hit = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_match[i] && (COUNT_W'(i) < count_ff)) begin
            any_hit = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      found_in  = 1'b0;
      status_in = ST_OK;
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctrl[i] = '0;
      end
      case (req_cmd)
         CMD_PUSH: begin
            if (count_ff >= COUNT_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               cell_ctrl[IDX_W'(count_ff)].load = accept;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         CMD_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in  = count_ff - COUNT_W'(1);
               popped_in = 64'(cell_key[top_idx]);
            end
         end
         CMD_REMOVE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!any_hit) begin
               status_in = ST_MISS;
            end else begin
               // slots from the hit upwards take their upper neighbour
               for (int i = 0; i < DEPTH - 1; i++) begin
                  cell_ctrl[i].shift = accept && (IDX_W'(i) >= hit_idx);
               end
               count_in = count_ff - COUNT_W'(1);
               found_in = 1'b1;
            end
         end
         default: begin
            found_in  = any_hit;
            status_in = any_hit ? ST_OK : ST_MISS;
         end
      endcase
   end

   assign next_top_idx = IDX_W'(count_in - COUNT_W'(1));
   assign top_in = (count_in != '0) ? 64'(cell_next[next_top_idx]) : 64'd0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped_in;
         found_ff  <= found_in;
         status_ff <= status_in;
         top_ff    <= top_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_popped_key  = popped_ff;
   assign rsp_found       = found_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = 4'(count_ff);
   assign rsp_top_key     = top_ff;
   assign rsp_top_valid   = (count_ff != '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction left no result");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (status_ff == ST_OK))
      else $error("match reported with failing status");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_POP && count_ff != '0) |=>
         (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("pop did not shrink the stack");

endmodule

// ===== rtl/kls_cell.sv =====
// one stack slot: holds a key, compares it, loads or takes the neighbour above
module kls_cell
   import kls_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  key_type       new_key,
   input  key_type       upper_key,
   output key_type       key_q,
   output key_type       key_next,
   output logic          match
);

   key_type key_ff;
   key_type key_in;

   always_comb begin
      key_in = key_ff;
      if (ctrl.load) begin
         key_in = new_key;
      end else if (ctrl.shift) begin
         key_in = upper_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_q    = key_ff;
   assign key_next = key_in;
   assign match    = (key_ff == new_key);

endmodule

// ===== tb/keyed_lifo_stack_tb.sv =====
// self-checking testbench of the keyed lifo stack with a predictor and a result scoreboard
module keyed_lifo_stack_tb
   import kls_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int MAX_REPORTS    = 40;

   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;

   typedef struct {
      key_type    popped_key;
      logic       found;
      logic [1:0] status;
      logic [3:0] entry_count;
      key_type    top_key;
      logic       top_valid;
   } stack_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_PUSH;
   logic [63:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [63:0] rsp_popped_key;
   logic        rsp_found;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_entry_count;
   logic [63:0] rsp_top_key;
   logic        rsp_top_valid;

   // predictor state
   key_type model_entries [DEPTH];
   int      model_fill = 0;

   stack_result_type expected_results [$];
   key_type          key_pool [8];

   int error_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   int max_gap     = 0;
   int stall_mode  = STALL_NONE;
   int stall_left  = 0;
   int ready_left  = 0;

   keyed_lifo_stack i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_popped_key  (rsp_popped_key),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_valid   (rsp_top_valid)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic stack_result_type predict_stack(input logic [1:0] cmd,
                                                      input key_type key);
      stack_result_type r;
      int hit;
      r.popped_key = '0;
      r.found      = 1'b0;
      r.status     = ST_OK;
      hit          = -1;
      case (cmd)
         CMD_PUSH: begin
            if (model_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_entries[model_fill] = key;
               model_fill++;
            end
         end
         CMD_POP: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               model_fill--;
               r.popped_key = model_entries[model_fill];
            end
         end
         CMD_REMOVE: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // topmost match wins
               for (int i = model_fill - 1; i >= 0; i--)
                  if (hit < 0 && model_entries[i] == key) hit = i;
               if (hit < 0) begin
                  r.status = ST_MISS;
               end else begin
                  for (int i = hit; i < model_fill - 1; i++)
                     model_entries[i] = model_entries[i + 1];
                  model_fill--;
                  r.found = 1'b1;
               end
            end
         end
         default: begin
            for (int i = 0; i < model_fill; i++)
               if (model_entries[i] == key) r.found = 1'b1;
            r.status = r.found ? ST_OK : ST_MISS;
         end
      endcase
      r.entry_count = 4'(model_fill);
      r.top_valid   = (model_fill > 0);
      r.top_key     = (model_fill > 0) ? model_entries[model_fill - 1] : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_REPORTS)
         $display("%0t ns: rsp %s got %h expected %h", $time, field, got, want);
      error_count++;
   endtask

   // one request transaction, with a random gap between bursts when max_gap is nonzero
   task automatic send_request(input logic [1:0] cmd, input key_type key);
      int gap;
      if (burst_left == 0) begin
         if (max_gap > 0) begin
            gap = $urandom_range(1, max_gap);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_stack(cmd, key));
      burst_left--;
   endtask

   function automatic key_type random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic key_type pick_key();
      if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 7)];
      return random_key();
   endfunction

   function automatic logic [1:0] pick_cmd(input int w_push, input int w_pop, input int w_remove);
      int r;
      r = $urandom_range(0, 99);
      if (r < w_push) return CMD_PUSH;
      if (r < w_push + w_pop) return CMD_POP;
      if (r < w_push + w_pop + w_remove) return CMD_REMOVE;
      return CMD_SEARCH;
   endfunction

   // small pool so that searches and removals hit, with duplicates likely
   task automatic refresh_key_pool();
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 8; i++) key_pool[i] = random_key();
   endtask

   task automatic run_random_items(input int count, input int w_push, input int w_pop,
                                   input int w_remove);
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) refresh_key_pool();
         send_request(pick_cmd(w_push, w_pop, w_remove), pick_key());
      end
   endtask

   task automatic test_directed();
      key_type key_a;
      key_a      = 64'h0123_4567_89ab_cdef;
      max_gap    = 3;
      stall_mode = STALL_RANDOM;
      send_request(CMD_SEARCH, key_a);
      send_request(CMD_POP, random_key());
      send_request(CMD_REMOVE, key_a);
      send_request(CMD_PUSH, '0);
      send_request(CMD_PUSH, '1);
      send_request(CMD_PUSH, key_a);
      send_request(CMD_PUSH, 64'h5555_5555_5555_5555);
      send_request(CMD_PUSH, key_a);
      send_request(CMD_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(CMD_PUSH, 64'h8000_0000_0000_0001);
      send_request(CMD_PUSH, 64'h7fff_ffff_ffff_fffe);
      // stack is full here
      send_request(CMD_PUSH, 64'hfeed_face_cafe_f00d);
      send_request(CMD_SEARCH, key_a);
      send_request(CMD_SEARCH, 64'hdead_beef_0bad_c0de);
      // duplicate key: only the upper copy goes, entries above shift down
      send_request(CMD_REMOVE, key_a);
      send_request(CMD_REMOVE, '0);
      send_request(CMD_REMOVE, 64'hdead_beef_0bad_c0de);
      repeat (6) send_request(CMD_POP, random_key());
   endtask

   task automatic test_random_mix();
      max_gap    = 6;
      stall_mode = STALL_PATTERN;
      run_random_items(500, 35, 20, 25);
   endtask

   task automatic test_fill_pressure();
      max_gap    = 3;
      stall_mode = STALL_RANDOM;
      run_random_items(250, 60, 10, 10);
   endtask

   task automatic test_drain_pressure();
      max_gap    = 8;
      stall_mode = STALL_PATTERN;
      run_random_items(250, 25, 30, 30);
   endtask

   task automatic test_back_to_back();
      max_gap    = 0;
      stall_mode = STALL_NONE;
      run_random_items(250, 40, 20, 20);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      case (stall_mode)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= 35);
         default: begin
            if (stall_left > 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else if (ready_left > 0) begin
               rsp_ready <= 1'b1;
               ready_left--;
            end else begin
               stall_left = $urandom_range(1, 6);
               ready_left = $urandom_range(1, 10);
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // result scoreboard
   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction, status", 64'(rsp_status), '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_popped_key !== want.popped_key)
               report_mismatch("popped_key", rsp_popped_key, want.popped_key);
            if (rsp_found !== want.found)
               report_mismatch("found", 64'(rsp_found), 64'(want.found));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.entry_count));
            if (rsp_top_key !== want.top_key)
               report_mismatch("top_key", rsp_top_key, want.top_key);
            if (rsp_top_valid !== want.top_valid)
               report_mismatch("top_valid", 64'(rsp_top_valid), 64'(want.top_valid));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix();
      test_fill_pressure();
      test_drain_pressure();
      test_back_to_back();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
